// ----- rtl/core/eight_bit_alu_with_flags_assert.svh -----
// Assertion macros for the ALU top file.
// Each check is clocked on the given clock and held off while reset is low.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: ante |-> cons
`define EALU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: ante |=> cons
`define EALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EALU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define EALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/ealu_pkg.sv -----
`timescale 1ns / 1ps

package ealu_pkg;

    localparam int MODE_W  = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;
    localparam int FLAG_W  = 4;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_ADC   = 5'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 5'd2;
    localparam logic [MODE_W-1:0] MODE_SBC   = 5'd3;
    localparam logic [MODE_W-1:0] MODE_AND   = 5'd4;
    localparam logic [MODE_W-1:0] MODE_XOR   = 5'd5;
    localparam logic [MODE_W-1:0] MODE_OR    = 5'd6;
    localparam logic [MODE_W-1:0] MODE_CP    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_INC   = 5'd8;
    localparam logic [MODE_W-1:0] MODE_DEC   = 5'd9;
    localparam logic [MODE_W-1:0] MODE_RLCA  = 5'd10;
    localparam logic [MODE_W-1:0] MODE_RRCA  = 5'd11;
    localparam logic [MODE_W-1:0] MODE_RLA   = 5'd12;
    localparam logic [MODE_W-1:0] MODE_RRA   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_DAA   = 5'd14;
    localparam logic [MODE_W-1:0] MODE_CPL   = 5'd15;
    localparam logic [MODE_W-1:0] MODE_SCF   = 5'd16;
    localparam logic [MODE_W-1:0] MODE_CCF   = 5'd17;
    localparam logic [MODE_W-1:0] MODE_RLC   = 5'd18;
    localparam logic [MODE_W-1:0] MODE_RRC   = 5'd19;
    localparam logic [MODE_W-1:0] MODE_RL    = 5'd20;
    localparam logic [MODE_W-1:0] MODE_RR    = 5'd21;
    localparam logic [MODE_W-1:0] MODE_SLA   = 5'd22;
    localparam logic [MODE_W-1:0] MODE_SRA   = 5'd23;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 5'd24;
    localparam logic [MODE_W-1:0] MODE_SRL   = 5'd25;
    localparam logic [MODE_W-1:0] MODE_BIT   = 5'd26;
    localparam logic [MODE_W-1:0] MODE_RES   = 5'd27;
    localparam logic [MODE_W-1:0] MODE_SET   = 5'd28;
    localparam logic [MODE_W-1:0] MODE_ADD16 = 5'd29;
    localparam logic [MODE_W-1:0] MODE_ADDSP = 5'd30;

    // Decimal adjust corrections
    localparam logic [BYTE_W-1:0] DAA_LO = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HI = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_MAX = 8'h99;
    localparam logic [3:0]        BCD_MAX = 4'h9;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [WORD_W-1:0]  operand_a;
        logic [WORD_W-1:0]  operand_b;
        logic [INDEX_W-1:0] bit_index;
        logic [FLAG_W-1:0]  flags_in;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
    } t_rsp;

endpackage

// ----- rtl/core/ealu_in_if.sv -----
`timescale 1ns / 1ps

interface ealu_in_if;
    logic                          valid;
    logic                          ready;
    logic [ealu_pkg::MODE_W-1:0]   mode;
    logic [ealu_pkg::WORD_W-1:0]   operand_a;
    logic [ealu_pkg::WORD_W-1:0]   operand_b;
    logic [ealu_pkg::INDEX_W-1:0]  bit_index;
    logic [ealu_pkg::FLAG_W-1:0]   flags_in;

    modport source (
        output valid, mode, operand_a, operand_b, bit_index, flags_in,
        input  ready
    );
    modport sink (
        input  valid, mode, operand_a, operand_b, bit_index, flags_in,
        output ready
    );
endinterface

// ----- rtl/core/ealu_out_if.sv -----
`timescale 1ns / 1ps

interface ealu_out_if;
    logic                         valid;
    logic                         ready;
    logic [ealu_pkg::WORD_W-1:0]  result;
    logic [ealu_pkg::FLAG_W-1:0]  flags_out;

    modport source (
        output valid, result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out,
        output ready
    );
endinterface

// ----- rtl/core/eight_bit_alu_with_flags.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// i_in      in   sink     mode, operand_a, operand_b, bit_index, flags_in
// o_out     out  source   result, flags_out
//
// One beat is accepted per cycle while i_in.ready is high; each result passes
// through the input register and then the result register.
// Reset (i_rst_n low, synchronous) empties both registers.
// A stalled output holds its beat; the input register keeps filling until
// both stages are full, then i_in.ready drops.

`include "eight_bit_alu_with_flags_assert.svh"

module eight_bit_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ealu_in_if.sink     i_in,
    ealu_out_if.source  o_out
);

    logic             r_v1;
    ealu_pkg::t_req   r_req;
    logic             r_v2;
    ealu_pkg::t_rsp   r_rsp;
    logic             n_v1;
    logic             n_v2;
    logic             s2_free;
    logic             s1_adv;
    logic             in_acc;
    ealu_pkg::t_rsp   w_rsp;

    // Handshake control
    assign s2_free    = !r_v2 || o_out.ready;
    assign s1_adv     = r_v1 && s2_free;
    assign i_in.ready = !r_v1 || s2_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign n_v1       = in_acc || (r_v1 && !s2_free);
    assign n_v2       = s1_adv || (r_v2 && !o_out.ready);

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // Capture input beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.mode      <= i_in.mode;
            r_req.operand_a <= i_in.operand_a;
            r_req.operand_b <= i_in.operand_b;
            r_req.bit_index <= i_in.bit_index;
            r_req.flags_in  <= i_in.flags_in;
        end
    end

    ealu_core u_core (
        .i_req (r_req),
        .o_rsp (w_rsp)
    );

    // Capture result
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out.valid     = r_v2;
    assign o_out.result    = r_rsp.result;
    assign o_out.flags_out = r_rsp.flags_out;

    `EALU_ASSERT_NXT(a_adv_fills_out, i_clk, i_rst_n, s1_adv, r_v2, "advanced beat lost")
    `EALU_ASSERT_NXT(a_blocked_holds, i_clk, i_rst_n, r_v1 && !s2_free, r_v1 && $stable(r_req), "blocked input register changed")
    `EALU_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, in_acc, !(r_v1 && r_v2 && !o_out.ready), "beat accepted into full pipe")
    `EALU_ASSERT_NOW(a_byte_high_zero, i_clk, i_rst_n, r_v1 && (r_req.mode < ealu_pkg::MODE_ADD16), w_rsp.result[15:8] == 8'h00, "byte op high byte set")

endmodule

// ----- rtl/core/ealu_core.sv -----
`timescale 1ns / 1ps

module ealu_core (
    input  ealu_pkg::t_req i_req,
    output ealu_pkg::t_rsp o_rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] a16;
    logic [15:0] b16;
    logic        fz, fn, fh, fc;
    logic        cin_add, cin_sub;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  inc8, dec8;
    logic [7:0]  daa_adj;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [7:0]  bit_mask;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [15:0] sp_r;
    logic [4:0]  sp_h5;
    logic [8:0]  sp_c9;
    logic [7:0]  r8;
    logic [15:0] r;
    logic        nz, nn, nh, nc;
    logic        wide;

    // Unpack operands and incoming flags
    assign a   = i_req.operand_a[7:0];
    assign b   = i_req.operand_b[7:0];
    assign a16 = i_req.operand_a;
    assign b16 = i_req.operand_b;
    assign fz  = i_req.flags_in[ealu_pkg::FLAG_Z];
    assign fn  = i_req.flags_in[ealu_pkg::FLAG_N];
    assign fh  = i_req.flags_in[ealu_pkg::FLAG_H];
    assign fc  = i_req.flags_in[ealu_pkg::FLAG_C];

    // 8-bit add and subtract over nine bits, nibble carries alongside
    assign cin_add = (i_req.mode == ealu_pkg::MODE_ADC) & fc;
    assign cin_sub = (i_req.mode == ealu_pkg::MODE_SBC) & fc;
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'b0, cin_add};
    assign hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin_add};
    assign dif9    = {1'b0, a} - {1'b0, b} - {8'b0, cin_sub};
    assign hdif5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin_sub};
    assign inc8    = a + 8'd1;
    assign dec8    = a - 8'd1;

    // Decimal adjust from incoming N, H and C
    always_comb begin
        daa_adj = '0;
        daa_c   = fc;
        if (fn) begin
            if (fh) daa_adj = daa_adj | ealu_pkg::DAA_LO;
            if (fc) daa_adj = daa_adj | ealu_pkg::DAA_HI;
            daa_r = a - daa_adj;
        end else begin
            if (fh || (a[3:0] > ealu_pkg::BCD_MAX)) daa_adj = daa_adj | ealu_pkg::DAA_LO;
            if (fc || (a > ealu_pkg::DAA_MAX)) begin
                daa_adj = daa_adj | ealu_pkg::DAA_HI;
                daa_c   = 1'b1;
            end
            daa_r = a + daa_adj;
        end
    end

    // 16-bit adds: register pair and signed offset
    assign bit_mask = 8'd1 << i_req.bit_index;
    assign sum17    = {1'b0, a16} + {1'b0, b16};
    assign hsum13   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    assign sp_r     = a16 + {{8{b[7]}}, b};
    assign sp_h5    = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
    assign sp_c9    = {1'b0, a16[7:0]} + {1'b0, b};

    // Select result and flags by operation
    always_comb begin
        r8   = a;
        wide = 1'b0;
        r    = a16;
        nz   = fz;
        nn   = fn;
        nh   = fh;
        nc   = fc;
        case (i_req.mode)
            ealu_pkg::MODE_ADD, ealu_pkg::MODE_ADC: begin
                r8 = sum9[7:0]; nz = (r8 == 8'h00); nn = 1'b0;
                nh = hsum5[4];  nc = sum9[8];
            end
            ealu_pkg::MODE_SUB, ealu_pkg::MODE_SBC, ealu_pkg::MODE_CP: begin
                r8 = dif9[7:0]; nz = (r8 == 8'h00); nn = 1'b1;
                nh = hdif5[4];  nc = dif9[8];
                if (i_req.mode == ealu_pkg::MODE_CP) r8 = a;
            end
            ealu_pkg::MODE_AND: begin
                r8 = a & b; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b1; nc = 1'b0;
            end
            ealu_pkg::MODE_XOR: begin
                r8 = a ^ b; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = 1'b0;
            end
            ealu_pkg::MODE_OR: begin
                r8 = a | b; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = 1'b0;
            end
            ealu_pkg::MODE_INC: begin
                r8 = inc8; nz = (r8 == 8'h00); nn = 1'b0; nh = (a[3:0] == 4'hf);
            end
            ealu_pkg::MODE_DEC: begin
                r8 = dec8; nz = (r8 == 8'h00); nn = 1'b1; nh = (a[3:0] == 4'h0);
            end
            ealu_pkg::MODE_RLCA, ealu_pkg::MODE_RLC: begin
                r8 = {a[6:0], a[7]};
                nz = (i_req.mode == ealu_pkg::MODE_RLC) && (r8 == 8'h00);
                nn = 1'b0; nh = 1'b0; nc = a[7];
            end
            ealu_pkg::MODE_RRCA, ealu_pkg::MODE_RRC: begin
                r8 = {a[0], a[7:1]};
                nz = (i_req.mode == ealu_pkg::MODE_RRC) && (r8 == 8'h00);
                nn = 1'b0; nh = 1'b0; nc = a[0];
            end
            ealu_pkg::MODE_RLA, ealu_pkg::MODE_RL: begin
                r8 = {a[6:0], fc};
                nz = (i_req.mode == ealu_pkg::MODE_RL) && (r8 == 8'h00);
                nn = 1'b0; nh = 1'b0; nc = a[7];
            end
            ealu_pkg::MODE_RRA, ealu_pkg::MODE_RR: begin
                r8 = {fc, a[7:1]};
                nz = (i_req.mode == ealu_pkg::MODE_RR) && (r8 == 8'h00);
                nn = 1'b0; nh = 1'b0; nc = a[0];
            end
            ealu_pkg::MODE_DAA: begin
                r8 = daa_r; nz = (r8 == 8'h00); nh = 1'b0; nc = daa_c;
            end
            ealu_pkg::MODE_CPL: begin
                r8 = ~a; nn = 1'b1; nh = 1'b1;
            end
            ealu_pkg::MODE_SCF: begin
                nn = 1'b0; nh = 1'b0; nc = 1'b1;
            end
            ealu_pkg::MODE_CCF: begin
                nn = 1'b0; nh = 1'b0; nc = ~fc;
            end
            ealu_pkg::MODE_SLA: begin
                r8 = {a[6:0], 1'b0}; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = a[7];
            end
            ealu_pkg::MODE_SRA: begin
                r8 = {a[7], a[7:1]}; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = a[0];
            end
            ealu_pkg::MODE_SWAP: begin
                r8 = {a[3:0], a[7:4]}; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = 1'b0;
            end
            ealu_pkg::MODE_SRL: begin
                r8 = {1'b0, a[7:1]}; nz = (r8 == 8'h00); nn = 1'b0; nh = 1'b0; nc = a[0];
            end
            ealu_pkg::MODE_BIT: begin
                nz = ~|(a & bit_mask); nn = 1'b0; nh = 1'b1;
            end
            ealu_pkg::MODE_RES: begin
                r8 = a & ~bit_mask;
            end
            ealu_pkg::MODE_SET: begin
                r8 = a | bit_mask;
            end
            ealu_pkg::MODE_ADD16: begin
                wide = 1'b1; r = sum17[15:0];
                nn = 1'b0; nh = hsum13[12]; nc = sum17[16];
            end
            ealu_pkg::MODE_ADDSP: begin
                wide = 1'b1; r = sp_r;
                nz = 1'b0; nn = 1'b0; nh = sp_h5[4]; nc = sp_c9[8];
            end
            default: begin
                // Unused code: pass the full operand and keep the flags
                wide = 1'b1;
            end
        endcase
    end

    assign o_rsp.result    = wide ? r : {8'h00, r8};
    assign o_rsp.flags_out = {nz, nn, nh, nc};

endmodule
